// File: design/bhs_pkg.sv
package bhs_pkg;

    // default sizes of the block
    localparam int DEF_CAPACITY     = 16;
    localparam int DEF_RECORD_WIDTH = 64;

    // fixed field widths of the request and result
    localparam int CMD_W      = 3;
    localparam int DEPTH_W    = 4;
    localparam int REC_PORT_W = 64;
    localparam int STATUS_W   = 2;
    localparam int CNT_PORT_W = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOP     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ITERATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]      cmd;
        logic [DEPTH_W-1:0]    depth_index;
        logic [REC_PORT_W-1:0] record_in;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [REC_PORT_W-1:0] record_out;
        logic [CNT_PORT_W-1:0] entry_count;
        logic                  last;
    } t_result;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ITER
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic                push;
        logic                pop;
        logic                clear;
        logic                rd_start;
        logic                rd_depth_in;
        logic                rd_next;
        logic                out_imm;
        logic [STATUS_W-1:0] imm_status;
        logic                out_rd;
        logic                out_last;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic depth_oob;
        logic iter_last;
    } t_dp_stat;

endpackage

// File: design/bounded_history_stack_unit.sv
// bounded history stack: a lifo of CAPACITY records that evicts the oldest
// record when a push arrives on a full stack
//
// request side: a request is taken at a rising edge where start is high and
// busy is low; i_req carries cmd, depth_index and record_in
// result side: each result sits on o_result for one cycle while
// o_result_valid is high; the receiver cannot stall, so it must take every
// result in that cycle
//
// latency: push, pop, clear, unused codes and all error cases give their
// single result in the cycle after the request; busy stays low, so a new
// request can go in every cycle
// top and query: result after the registered read of the record store and the
// result register, busy for one cycle
// iterate: one result per cycle for each held record, newest first, the
// first after the registered read and the result register; busy while the
// records are read out; the last result carries last
//
// reset (synchronous, active low) empties the stack and drops any pending
// result; the record store itself is not cleared
module bounded_history_stack_unit #(
    parameter int CAPACITY     = bhs_pkg::DEF_CAPACITY,
    parameter int RECORD_WIDTH = bhs_pkg::DEF_RECORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  bhs_pkg::t_req    i_req,
    output logic             busy,
    output logic             o_result_valid,
    output bhs_pkg::t_result o_result
);
    import bhs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing of each request
    bhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_req.cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // ring store, pointers and result register
    bhs_datapath #(
        .CAPACITY     (CAPACITY),
        .RECORD_WIDTH (RECORD_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // a push always answers ok in the next cycle
    a_push_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.cmd == CMD_PUSH)
        |=> (o_result_valid && o_result.status == ST_OK && o_result.last))
        else $error("push not answered in next cycle");

    // error results carry no record
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_OK) |-> (o_result.record_out == '0))
        else $error("error result with nonzero record");

    // the final result of a request frees the block
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.last) |-> !busy)
        else $error("busy after final result");

    // count never exceeds capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (32'(o_result.entry_count) <= CAPACITY))
        else $error("entry count above capacity");

endmodule

// File: design/bhs_ctrl.sv
module bhs_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [bhs_pkg::CMD_W-1:0] i_cmd,
    input  bhs_pkg::t_dp_stat         i_stat,
    output bhs_pkg::t_dp_cmd          o_cmd,
    output logic                      busy
);
    import bhs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_stat.count_zero) begin
                    case (i_cmd)
                        CMD_TOP:     n_state = S_READ;
                        CMD_QUERY:   n_state = i_stat.depth_oob ? S_IDLE : S_READ;
                        CMD_ITERATE: n_state = S_ITER;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:  n_state = S_IDLE;
            S_ITER:  n_state = i_stat.iter_last ? S_IDLE : S_ITER;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.imm_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            o_cmd.push    = 1'b1;
                            o_cmd.out_imm = 1'b1;
                        end
                        CMD_POP: begin
                            o_cmd.out_imm = 1'b1;
                            if (i_stat.count_zero) begin
                                o_cmd.imm_status = ST_EMPTY;
                            end else begin
                                o_cmd.pop = 1'b1;
                            end
                        end
                        CMD_TOP, CMD_ITERATE: begin
                            if (i_stat.count_zero) begin
                                o_cmd.out_imm    = 1'b1;
                                o_cmd.imm_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_start = 1'b1;
                            end
                        end
                        CMD_QUERY: begin
                            if (i_stat.count_zero) begin
                                o_cmd.out_imm    = 1'b1;
                                o_cmd.imm_status = ST_EMPTY;
                            end else if (i_stat.depth_oob) begin
                                o_cmd.out_imm    = 1'b1;
                                o_cmd.imm_status = ST_RANGE;
                            end else begin
                                o_cmd.rd_start    = 1'b1;
                                o_cmd.rd_depth_in = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            o_cmd.clear   = 1'b1;
                            o_cmd.out_imm = 1'b1;
                        end
                        default: begin
                            o_cmd.out_imm = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.out_rd   = 1'b1;
                o_cmd.out_last = 1'b1;
            end
            S_ITER: begin
                o_cmd.out_rd   = 1'b1;
                o_cmd.out_last = i_stat.iter_last;
                o_cmd.rd_next  = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: design/bhs_datapath.sv
module bhs_datapath #(
    parameter int CAPACITY     = bhs_pkg::DEF_CAPACITY,
    parameter int RECORD_WIDTH = bhs_pkg::DEF_RECORD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bhs_pkg::t_req    i_req,
    input  bhs_pkg::t_dp_cmd i_cmd,
    output bhs_pkg::t_dp_stat o_stat,
    output logic             o_result_valid,
    output bhs_pkg::t_result o_result
);
    import bhs_pkg::*;

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > DEPTH_W) ? CW : DEPTH_W;

    logic [RECORD_WIDTH-1:0] r_mem [CAPACITY];
    logic [RECORD_WIDTH-1:0] r_rd_data;
    logic [PW-1:0]           r_top;
    logic [PW-1:0]           n_top;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [PW-1:0]           r_idx;
    logic                    r_out_valid;
    t_result                 r_out;

    logic [PW-1:0]           top_inc;
    logic [PW-1:0]           rd_depth;
    logic [PW:0]             rd_diff;
    logic [PW-1:0]           rd_addr;
    logic                    rd_en;

    // status toward the controller
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.depth_oob  = (XW'(i_req.depth_index) >= XW'(r_count));
    assign o_stat.iter_last  = ((CW'(r_idx) + CW'(1)) == r_count);

    // ring pointer and count updates
    assign top_inc = (r_top == PW'(CAPACITY - 1)) ? '0 : r_top + PW'(1);

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        if (i_cmd.push) begin
            n_top   = top_inc;
            n_count = (r_count == CW'(CAPACITY)) ? r_count : r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_top   = (r_top == '0) ? PW'(CAPACITY - 1) : r_top - PW'(1);
            n_count = r_count - CW'(1);
        end else if (i_cmd.clear) begin
            n_top   = '0;
            n_count = '0;
        end
    end

    // depth to ring slot
    always_comb begin
        if (i_cmd.rd_start) begin
            rd_depth = i_cmd.rd_depth_in ? PW'(i_req.depth_index) : '0;
        end else begin
            rd_depth = r_idx + PW'(1);
        end
        rd_diff = {1'b0, r_top} - {1'b0, rd_depth};
        rd_addr = rd_diff[PW] ? PW'(rd_diff + (PW + 1)'(CAPACITY)) : rd_diff[PW-1:0];
        rd_en   = i_cmd.rd_start || (i_cmd.rd_next && !o_stat.iter_last);
    end

    // record store
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[top_inc] <= RECORD_WIDTH'(i_req.record_in);
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_count     <= n_count;
            r_out_valid <= i_cmd.out_imm || i_cmd.out_rd;
            if (i_cmd.rd_start) begin
                r_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_idx <= r_idx + PW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_imm) begin
            r_out.status      <= i_cmd.imm_status;
            r_out.record_out  <= '0;
            r_out.entry_count <= CNT_PORT_W'(n_count);
            r_out.last        <= 1'b1;
        end else if (i_cmd.out_rd) begin
            r_out.status      <= ST_OK;
            r_out.record_out  <= REC_PORT_W'(r_rd_data);
            r_out.entry_count <= CNT_PORT_W'(r_count);
            r_out.last        <= i_cmd.out_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule
